FILE: sv/cvr_pkg.sv
// shared types and constants of the change-of-value reporter
`default_nettype none

package cvr_pkg;

  localparam int SampleW = 16;
  localparam int TimeW   = 48;
  localparam int TdataW  = 64;
  localparam int CfgIdxW = 8;
  localparam int CfgDatW = 24;
  localparam int FifoD   = 4;
  localparam int PtrW    = $clog2(FifoD);
  localparam int CntW    = $clog2(FifoD + 1);

  // register indexes on the configuration channel
  localparam logic [CfgIdxW-1:0] REG_TRIGGER_MODE   = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_TRIGGER_LEVEL  = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_FORCE_INTERVAL = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_POST_ENABLE    = 8'd3;

  // trigger modes
  localparam logic [1:0] TRIG_NONE      = 2'd0;
  localparam logic [1:0] TRIG_DEADBAND  = 2'd1;
  localparam logic [1:0] TRIG_THRESHOLD = 2'd2;

  typedef struct packed {
    logic              last;
    logic              replay;
    logic [TimeW-1:0]  ts;
    logic signed [SampleW-1:0] value;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/change_of_value_reporter.sv
// change-of-value reporter: deadband / threshold report-by-exception filter
//
//   channel   dir  handshake             payload
//   s_axis    in   tvalid/tready         tdata = sample, timestamp
//   m_axis    out  tvalid/tready         tdata = value, timestamp; tuser = replay; tlast
//   cfg       in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// one input beat per cycle while the queue has room: a beat is registered, then decided and posted
// a post with replay produces two output beats, so the output port sets the pace then
// results sit in a four-entry queue; input stalls only while fewer than two slots are free
// rst is synchronous and clears state, queue and registers; cfg_ready is always high
`default_nettype none

module change_of_value_reporter import cvr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TdataW-1:0]  s_axis_tdata,   // [15:0] sample, [63:16] timestamp
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TdataW-1:0]  m_axis_tdata,   // [15:0] out_value, [63:16] out_timestamp
  output logic               m_axis_tuser,   // [0] is_replay
  output logic               m_axis_tlast,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgDatW-1:0] cfg_data
);

  // configuration
  logic [1:0]         trigger_mode;
  logic [15:0]        trigger_level;
  logic [23:0]        force_interval;
  logic               post_enable;

  // channel state
  logic signed [SampleW-1:0] prev_value;
  logic [TimeW-1:0]   prev_time;
  logic               prev_valid;
  logic signed [SampleW-1:0] posted_value;
  logic [TimeW-1:0]   posted_time;
  logic               prev_was_posted;

  // input register
  logic               s1_valid;
  logic signed [SampleW-1:0] s1_sample;
  logic [TimeW-1:0]   s1_ts;

  // result queue
  result_t            fifo [FifoD];
  logic [PtrW-1:0]    wr_ptr;
  logic [PtrW-1:0]    rd_ptr;
  logic [CntW-1:0]    count;
  logic [CntW-1:0]    count_next;

  logic [TimeW-1:0]   elapsed;
  logic               due;
  logic               fire;
  logic               post;
  logic               replay;
  logic               s1_fire;
  logic               pop;
  logic [1:0]         n_push;
  logic signed [SampleW:0] diff;
  logic [SampleW:0]   diff_abs;
  logic               v_below;
  logic               ref_below;
  logic               zero_change;
  result_t            cur_res;
  result_t            rep_res;
  result_t            head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_mode   <= TRIG_NONE;
      trigger_level  <= '0;
      force_interval <= '0;
      post_enable    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TRIGGER_MODE:   trigger_mode   <= cfg_data[1:0];
        REG_TRIGGER_LEVEL:  trigger_level  <= cfg_data[15:0];
        REG_FORCE_INTERVAL: force_interval <= cfg_data;
        REG_POST_ENABLE:    post_enable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // decision on the registered beat
  always_comb begin
    elapsed = s1_ts - posted_time;
    due     = (force_interval != '0) && (elapsed > {24'd0, force_interval});

    diff     = {s1_sample[SampleW-1], s1_sample} - {posted_value[SampleW-1], posted_value};
    diff_abs = diff[SampleW] ? (SampleW+1)'(-diff) : diff;
    // levels are unsigned, so compare in 17-bit signed
    v_below   = $signed({s1_sample[SampleW-1], s1_sample}) < $signed({1'b0, trigger_level});
    ref_below = $signed({posted_value[SampleW-1], posted_value})
                < $signed({1'b0, trigger_level});
    zero_change = (posted_value == '0) != (s1_sample == '0);

    unique case (trigger_mode)
      TRIG_DEADBAND:  fire = diff_abs > {1'b0, trigger_level};
      TRIG_THRESHOLD: fire = zero_change || (v_below != ref_below);
      default:        fire = 1'b0;
    endcase

    post    = post_enable && (due || fire);
    replay  = post && !prev_was_posted && prev_valid;
    s1_fire = s1_valid && (count <= CntW'(FifoD - 2));
    pop     = m_axis_tvalid && m_axis_tready;

    if (s1_fire && post) n_push = replay ? 2'd2 : 2'd1;
    else                 n_push = 2'd0;

    count_next = count + CntW'(n_push) - CntW'(pop);

    cur_res = '{last: 1'b1, replay: 1'b0, ts: s1_ts, value: s1_sample};
    rep_res = '{last: 1'b0, replay: 1'b1, ts: prev_time, value: prev_value};
  end

  assign s_axis_tready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_sample <= s_axis_tdata[SampleW-1:0];
      s1_ts     <= s_axis_tdata[SampleW +: TimeW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_value      <= '0;
      prev_time       <= '0;
      prev_valid      <= 1'b0;
      posted_value    <= '0;
      posted_time     <= '0;
      prev_was_posted <= 1'b0;
    end else if (s1_fire) begin
      prev_value      <= s1_sample;
      prev_time       <= s1_ts;
      prev_valid      <= 1'b1;
      prev_was_posted <= post;
      if (post) begin
        posted_value <= s1_sample;
        posted_time  <= s1_ts;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && post) begin
      if (replay) begin
        fifo[wr_ptr]          <= rep_res;
        fifo[wr_ptr + 2'd1]   <= cur_res;
      end else begin
        fifo[wr_ptr] <= cur_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(n_push);
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count_next;
    end
  end

  assign head          = fifo[rd_ptr];
  assign m_axis_tvalid = count != '0;
  assign m_axis_tdata  = {head.ts, head.value};
  assign m_axis_tuser  = head.replay;
  assign m_axis_tlast  = head.last;

endmodule

`default_nettype wire

FILE: sv/cvr_checker.sv
// port-level checks for the change-of-value reporter, bound to the top level
`default_nettype none

module cvr_checker import cvr_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [TdataW-1:0] m_axis_tdata,
  input logic              m_axis_tuser,
  input logic              m_axis_tlast
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  // a replayed sample never closes the results of an input
  a_replay_not_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> !m_axis_tlast)
    else $error("replay beat marked last");

  // the current sample is queued with its replay, so it follows at once
  a_replay_then_current: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tuser |=>
      m_axis_tvalid && !m_axis_tuser && m_axis_tlast)
    else $error("replay not followed by current sample");

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind change_of_value_reporter cvr_checker u_cvr_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

FILE: verif/cvr_post_checker.sv
// post predictor and output checker for the change-of-value reporter testbench
module cvr_post_checker import cvr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [TdataW-1:0]  s_axis_tdata,   // [15:0] sample, [63:16] timestamp
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [TdataW-1:0]  m_axis_tdata,   // [15:0] out_value, [63:16] out_timestamp
  input  logic               m_axis_tuser,   // [0] is_replay
  input  logic               m_axis_tlast,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgDatW-1:0] cfg_data,
  output int                 fail_count,
  output int                 pending_posts,
  output int                 posts_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copies
  logic [1:0]         mode;
  logic [15:0]        level;
  logic [23:0]        interval_ms;
  logic               enable;

  // channel history
  logic signed [15:0] last_value;
  logic [TimeW-1:0]   last_time;
  logic               have_last;
  logic signed [15:0] posted_value;
  logic [TimeW-1:0]   posted_time;
  logic               last_was_posted;

  result_t            expected_posts[$];

  task automatic predict_posts(input logic signed [15:0] v, input logic [TimeW-1:0] t);
    logic [TimeW-1:0] elapsed;
    logic             due;
    logic             trig;
    int               diff;
    result_t          r;
    elapsed = t - posted_time;
    due = (interval_ms != 0) && (elapsed > TimeW'(interval_ms));
    trig = 1'b0;
    case (mode)
      TRIG_DEADBAND: begin
        diff = int'(v) - int'(posted_value);
        if (diff < 0) diff = -diff;
        trig = diff > int'(level);
      end
      TRIG_THRESHOLD: begin
        trig = ((posted_value == 0) != (v == 0)) ||
               ((int'(v) < int'(level)) != (int'(posted_value) < int'(level)));
      end
      default: trig = 1'b0;
    endcase
    if (enable && (due || trig)) begin
      // an unposted previous sample goes out ahead of this one
      if (!last_was_posted && have_last) begin
        r.value  = last_value;
        r.ts     = last_time;
        r.replay = 1'b1;
        r.last   = 1'b0;
        expected_posts.push_back(r);
      end
      r.value  = v;
      r.ts     = t;
      r.replay = 1'b0;
      r.last   = 1'b1;
      expected_posts.push_back(r);
      last_was_posted = 1'b1;
      posted_value    = v;
      posted_time     = t;
    end else begin
      last_was_posted = 1'b0;
    end
    last_value = v;
    last_time  = t;
    have_last  = 1'b1;
  endtask

  task automatic check_beat();
    result_t want;
    if (expected_posts.size() == 0) begin
      $error("unexpected output beat: out_value %0d out_timestamp %0d",
             $signed(m_axis_tdata[15:0]), m_axis_tdata[63:16]);
      fail_count++;
    end else begin
      want = expected_posts.pop_front();
      posts_checked++;
      if (m_axis_tdata[15:0] !== want.value) begin
        $error("out_value: expected %0d, got %0d", $signed(want.value),
               $signed(m_axis_tdata[15:0]));
        fail_count++;
      end
      if (m_axis_tdata[63:16] !== want.ts) begin
        $error("out_timestamp: expected %0d, got %0d", want.ts, m_axis_tdata[63:16]);
        fail_count++;
      end
      if (m_axis_tuser !== want.replay) begin
        $error("is_replay: expected %0b, got %0b", want.replay, m_axis_tuser);
        fail_count++;
      end
      if (m_axis_tlast !== want.last) begin
        $error("out_last: expected %0b, got %0b", want.last, m_axis_tlast);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_posts.delete();
      mode            = TRIG_NONE;
      level           = '0;
      interval_ms     = '0;
      enable          = 1'b0;
      last_value      = '0;
      last_time       = '0;
      have_last       = 1'b0;
      posted_value    = '0;
      posted_time     = '0;
      last_was_posted = 1'b0;
      pending_posts   = 0;
    end else begin
      // outputs always belong to older samples, so compare before predicting
      if (m_axis_tvalid && m_axis_tready) check_beat();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TRIGGER_MODE:   mode        = cfg_data[1:0];
          REG_TRIGGER_LEVEL:  level       = cfg_data[15:0];
          REG_FORCE_INTERVAL: interval_ms = cfg_data[23:0];
          REG_POST_ENABLE:    enable      = cfg_data[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_posts(s_axis_tdata[15:0], s_axis_tdata[63:16]);
      pending_posts = expected_posts.size();
    end
  end

endmodule

FILE: verif/tb.sv
// stimulus top for the change-of-value reporter: drives samples and registers, gives the verdict
module tb import cvr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] TRIG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 150;

  logic               clk = 1'b0;
  logic               rst;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [TdataW-1:0]  s_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [TdataW-1:0]  m_axis_tdata;
  logic               m_axis_tuser;
  logic               m_axis_tlast;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDatW-1:0] cfg_data;

  int                 fail_count;
  int                 pending_posts;
  int                 posts_checked;

  int                 tx_idle_pct;
  int                 rx_stall_pct;
  int                 cycle_count;
  int                 items_sent;
  int                 settings_used;
  int                 walk_value;
  int                 walk_step;
  logic [TimeW-1:0]   now_ms;
  logic [23:0]        cur_interval;

  change_of_value_reporter dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  cvr_post_checker u_post_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_posts (pending_posts),
    .posts_checked (posts_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic configure(input logic [1:0] m, input logic [15:0] lvl,
                           input logic [23:0] ivl, input logic en);
    write_reg(REG_TRIGGER_MODE, CfgDatW'(m));
    write_reg(REG_TRIGGER_LEVEL, CfgDatW'(lvl));
    write_reg(REG_FORCE_INTERVAL, CfgDatW'(ivl));
    write_reg(REG_POST_ENABLE, CfgDatW'(en));
    cfg_valid <= 1'b0;
    cur_interval = ivl;
    settings_used++;
  endtask

  // hold the input off until every predicted beat is out and the pipe is empty
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_posts != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_sample(input logic signed [15:0] v, input logic [TimeW-1:0] t);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {t, v};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // random walk with occasional extremes, zeros and repeats
  function automatic logic signed [15:0] next_sample();
    int pick;
    int s;
    int jitter;
    pick = $urandom_range(0, 19);
    if (pick == 0) s = 32767;
    else if (pick == 1) s = -32768;
    else if (pick == 2) s = 0;
    else if (pick == 3) s = int'($signed(16'($urandom)));
    else if (pick < 8) s = walk_value;
    else begin
      jitter = $urandom_range(0, 2 * walk_step);
      s = walk_value + jitter - walk_step;
    end
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    walk_value = s;
    return 16'(s);
  endfunction

  // mostly small steps, some near the interval, rare repeats and far jumps
  function automatic void advance_time();
    int unsigned pick;
    int unsigned span;
    pick = $urandom_range(0, 19);
    span = (cur_interval == 0) ? 300 : cur_interval / 8 + 1;
    if (pick == 0) now_ms = {16'($urandom), 32'($urandom)};
    else if (pick == 1 && cur_interval != 0)
      now_ms = now_ms + cur_interval + $urandom_range(0, 2);
    else if (pick != 2) now_ms = now_ms + $urandom_range(1, span);
  endfunction

  task automatic phase_settings(input int p);
    logic [1:0]  m;
    logic [15:0] lvl;
    logic [23:0] ivl;
    logic        en;
    m   = ($urandom_range(0, 1) == 0) ? TRIG_DEADBAND : TRIG_THRESHOLD;
    if ($urandom_range(0, 7) == 0) m = ($urandom_range(0, 1) == 0) ? TRIG_NONE : TRIG_UNUSED;
    lvl = 16'($urandom_range(0, 1500));
    ivl = ($urandom_range(0, 2) == 0) ? 24'd0 : 24'($urandom_range(1, 5000));
    en  = ($urandom_range(0, 9) != 0);
    case (p)
      0: begin
        m = TRIG_DEADBAND;  lvl = 16'd0;      ivl = 24'd1;        en = 1'b1;
      end
      1: begin
        m = TRIG_THRESHOLD; lvl = 16'd0;      ivl = 24'd0;        en = 1'b1;
      end
      2: begin
        m = TRIG_DEADBAND;  lvl = 16'hffff;   ivl = 24'hffffff;   en = 1'b1;
      end
      3: begin
        m = TRIG_THRESHOLD; lvl = 16'hffff;   ivl = 24'd0;        en = 1'b1;
      end
      4: begin
        m = TRIG_UNUSED;    ivl = 24'($urandom_range(1, 3000));   en = 1'b1;
      end
      5: en = 1'b0;
      default: ;
    endcase
    configure(m, lvl, ivl, en);
  endtask

  initial begin
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b1;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    cycle_count   = 0;
    items_sent    = 0;
    settings_used = 0;
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    walk_value    = 0;
    walk_step     = 100;
    now_ms        = '0;
    cur_interval  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // deadband with interval: first sample, replay, extremes, interval boundary
    configure(TRIG_DEADBAND, 16'd100, 24'd1000, 1'b1);
    send_sample(16'sd0, 48'd10);
    send_sample(16'sd50, 48'd20);
    send_sample(16'sd150, 48'd30);
    send_sample(16'sd300, 48'd40);
    send_sample(16'sh7fff, 48'd50);
    send_sample(16'sh8000, 48'd60);
    send_sample(16'sh8000, 48'd2000);
    send_sample(16'sh8000, 48'd3000);
    send_sample(16'sh8000, 48'd3001);
    wait_idle();

    // threshold at zero: sign split and zero transitions
    configure(TRIG_THRESHOLD, 16'd0, 24'd0, 1'b1);
    send_sample(16'sd5, 48'd3002);
    send_sample(16'sd0, 48'd3003);
    send_sample(16'sd7, 48'd3004);
    send_sample(16'sd8, 48'd3005);
    send_sample(-16'sd1, 48'd3006);
    wait_idle();

    // unused mode, widest interval, timestamps wrapping past zero
    configure(TRIG_UNUSED, 16'd0, 24'hffffff, 1'b1);
    send_sample(16'sd1234, 48'hffff_ffff_fff0);
    send_sample(-16'sd1, 48'd5);
    send_sample(-16'sd1, 48'h0000_00ff_fff0);
    wait_idle();

    // disabled channel, then widest deadband that cannot fire
    configure(TRIG_DEADBAND, 16'hffff, 24'd0, 1'b0);
    send_sample(16'sh7fff, 48'h0000_0100_0000);
    send_sample(16'sh8000, 48'h0000_0100_0001);
    wait_idle();
    configure(TRIG_DEADBAND, 16'hffff, 24'd0, 1'b1);
    send_sample(16'sh7fff, 48'h0000_0100_0002);
    wait_idle();
    configure(TRIG_NONE, 16'd0, 24'd1, 1'b1);
    send_sample(16'sh7fff, 48'h0000_0100_0004);
    send_sample(16'sh7fff, 48'h0000_0100_0005);
    send_sample(16'sh7fff, 48'h0000_0100_0007);
    wait_idle();

    now_ms = 48'h0000_0100_0008;
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin
          tx_idle_pct = 0;  rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct = 58; rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct = 0;  rx_stall_pct = 58;
        end
        default: begin
          tx_idle_pct = 32; rx_stall_pct = 32;
        end
      endcase
      wait_idle();
      phase_settings(p);
      walk_step  = $urandom_range(1, 600);
      walk_value = $urandom_range(0, 3000) - 1500;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) wait_idle();
        advance_time();
        send_sample(next_sample(), now_ms);
      end
    end

    wait_idle();
    $display("tb: %0d samples under %0d register settings, %0d output beats checked",
             items_sent, settings_used, posts_checked);
    $display("tb: idle mixes covered none, sender gaps, receiver stalls and both");
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/cvr_pkg.sv
sv/change_of_value_reporter.sv
sv/cvr_checker.sv
verif/cvr_post_checker.sv
verif/tb.sv
